// ===== design/gamepad_event_report_builder_assert.svh =====
// Assertion macros for the gamepad event report builder.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef GAMEPAD_EVENT_REPORT_BUILDER_ASSERT_SVH
`define GAMEPAD_EVENT_REPORT_BUILDER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define GERB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define GERB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gerb_pkg.sv =====
// Shared types, codes and the button position table of the report builder.
// No dependencies.
package gerb_pkg;

    localparam int REPORT_LEN   = 7;
    localparam int BUTTON_COUNT = 17;
    localparam int IN_WIDTH     = 32;
    localparam int OUT_WIDTH    = REPORT_LEN * 8;

    localparam logic [1:0] KIND_BUTTON = 2'd0;
    localparam logic [1:0] KIND_AXIS   = 2'd1;

    localparam logic [7:0] AXIS_LEFT_X  = 8'd0;
    localparam logic [7:0] AXIS_LEFT_Y  = 8'd1;
    localparam logic [7:0] AXIS_RIGHT_X = 8'd3;
    localparam logic [7:0] AXIS_RIGHT_Y = 8'd4;
    localparam logic [7:0] AXIS_HAT_X   = 8'd6;
    localparam logic [7:0] AXIS_HAT_Y   = 8'd7;

    // First of the two button slots that each hat axis drives
    localparam logic [7:0] HAT_X_FIRST = 8'd15;
    localparam logic [7:0] HAT_Y_FIRST = 8'd13;

    localparam logic [7:0] AXIS_REST = 8'd127;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         number;
        logic signed [15:0] value;
    } event_t;

    typedef logic [REPORT_LEN-1:0][7:0] report_t;

    typedef struct packed {
        logic [2:0] byte_sel;
        logic [2:0] bit_sel;
    } btn_pos_t;

    typedef struct packed {
        logic advance;
        logic emit;
    } stage_ctrl_t;

    localparam report_t REPORT_RESET = {8'd0, 8'd0, 8'd0,
                                        AXIS_REST, AXIS_REST, AXIS_REST, AXIS_REST};

    function automatic btn_pos_t btn_pos(input logic [4:0] n);
        btn_pos_t p;
        case (n)
            5'd0:    p = '{3'd4, 3'd5};
            5'd1:    p = '{3'd4, 3'd6};
            5'd2:    p = '{3'd4, 3'd7};
            5'd3:    p = '{3'd4, 3'd4};
            5'd4:    p = '{3'd5, 3'd0};
            5'd5:    p = '{3'd5, 3'd1};
            5'd6:    p = '{3'd5, 3'd2};
            5'd7:    p = '{3'd5, 3'd3};
            5'd8:    p = '{3'd5, 3'd4};
            5'd9:    p = '{3'd5, 3'd5};
            5'd10:   p = '{3'd6, 3'd0};
            5'd11:   p = '{3'd5, 3'd6};
            5'd12:   p = '{3'd5, 3'd7};
            5'd13:   p = '{3'd4, 3'd1};
            5'd14:   p = '{3'd4, 3'd3};
            5'd15:   p = '{3'd4, 3'd0};
            5'd16:   p = '{3'd4, 3'd2};
            default: p = '{3'd4, 3'd0};
        endcase
        return p;
    endfunction

endpackage

// ===== design/gerb_in_reg.sv =====
// Input register of the report builder: takes one event item per cycle while s_tready is high.
// Depends on gerb_pkg.
module gerb_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  gerb_pkg::stage_ctrl_t ctrl,
    output logic                 ev_valid,
    output gerb_pkg::event_t     ev
);
    import gerb_pkg::*;

    logic   valid_reg;
    event_t ev_reg;
    logic   take;

    assign s_tready = !valid_reg || ctrl.advance;
    assign take     = s_tvalid && s_tready;
    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ev_reg.kind   <= s_tdata[1:0];
            ev_reg.number <= s_tdata[9:2];
            ev_reg.value  <= s_tdata[25:10];
        end
    end

endmodule

// ===== design/gerb_report_core.sv =====
// Report state and the update logic for one event item.
// Depends on gerb_pkg.
module gerb_report_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ev_valid,
    input  gerb_pkg::event_t      ev,
    input  logic                  out_free,
    output gerb_pkg::stage_ctrl_t ctrl,
    output gerb_pkg::report_t     report_next,
    output gerb_pkg::report_t     report_state
);
    import gerb_pkg::*;

    report_t report_reg;
    report_t rep;
    logic    emit;

    // (v + 32767) >> 8, with the most negative value held at zero
    function automatic logic [7:0] normalize_axis(input logic signed [15:0] v);
        logic [16:0] sum;
        sum = {v[15], v} + 17'sd32767;
        return sum[16] ? 8'd0 : sum[15:8];
    endfunction

    assign emit = (ev.kind == KIND_BUTTON) || (ev.kind == KIND_AXIS);

    assign ctrl.emit    = emit;
    assign ctrl.advance = ev_valid && (!emit || out_free);

    always_comb
    begin
        btn_pos_t p0;
        btn_pos_t p1;
        logic [7:0] first;
        rep   = report_reg;
        first = (ev.number == AXIS_HAT_Y) ? HAT_Y_FIRST : HAT_X_FIRST;
        p0    = btn_pos(first[4:0]);
        p1    = btn_pos(first[4:0] + 5'd1);
        case (ev.kind)
            KIND_BUTTON:
            begin
                if (ev.number < 8'(BUTTON_COUNT))
                begin
                    p0 = btn_pos(ev.number[4:0]);
                    rep[p0.byte_sel][p0.bit_sel] = (ev.value != 16'sd0);
                end
            end
            KIND_AXIS:
            begin
                case (ev.number)
                    AXIS_LEFT_X:  rep[0] = normalize_axis(ev.value);
                    AXIS_LEFT_Y:  rep[1] = normalize_axis(ev.value);
                    AXIS_RIGHT_X: rep[2] = normalize_axis(ev.value);
                    AXIS_RIGHT_Y: rep[3] = normalize_axis(ev.value);
                    AXIS_HAT_X, AXIS_HAT_Y:
                    begin
                        if (ev.value < 16'sd0)
                        begin
                            rep[p0.byte_sel][p0.bit_sel] = 1'b1;
                        end
                        else if (ev.value > 16'sd0)
                        begin
                            rep[p1.byte_sel][p1.bit_sel] = 1'b1;
                        end
                        else
                        begin
                            rep[p0.byte_sel][p0.bit_sel] = 1'b0;
                            rep[p1.byte_sel][p1.bit_sel] = 1'b0;
                        end
                    end
                    default: rep = report_reg;
                endcase
            end
            default: rep = report_reg;
        endcase
    end

    assign report_next  = rep;
    assign report_state = report_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_reg <= REPORT_RESET;
        end
        else if (ctrl.advance && emit)
        begin
            report_reg <= rep;
        end
    end

endmodule

// ===== design/gerb_out_reg.sv =====
// Result register of the report builder: holds one report until taken.
// Depends on gerb_pkg.
module gerb_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gerb_pkg::stage_ctrl_t ctrl,
    input  gerb_pkg::report_t     report_next,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata
);
    import gerb_pkg::*;

    logic    valid_reg;
    report_t data_reg;
    logic    load;

    assign load     = ctrl.advance && ctrl.emit;
    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= report_next;
        end
    end

endmodule

// ===== design/gamepad_event_report_builder.sv =====
// Top level of the gamepad event report builder.
// Depends on gerb_pkg, gerb_in_reg, gerb_report_core, gerb_out_reg and the assert header.
//
// Usage:
//   Event items enter on the s_ stream channel; each one is a joystick event
//   (kind, number, value). Button and axis events update a seven-byte
//   controller report and send the whole report out as one item on the m_
//   channel. Other event kinds change nothing and send nothing.
//   An accepted item passes the input register, then the result register,
//   which raises m_tvalid with the report. Throughput: one item per cycle,
//   sustained, as long as the receiver takes results. The path that sets
//   that figure is the report update between the two registers: a table
//   lookup, one or two bit writes or one 17-bit add with a shift.
//   When the receiver stalls, the result register holds its report and the
//   input register holds the next event; s_tready drops only when both are
//   full. Events that emit nothing still drain while the output stalls.
//   Reset clears both stages and sets report bytes 0 to 3 to 127 (sticks
//   centered) and bytes 4 to 6 to zero (no buttons).
module gamepad_event_report_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: event_kind[1:0], event_number[9:2],
    // event_value[25:10] (signed), zero fill [31:26]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: left_stick_x, left_stick_y, right_stick_x,
    // right_stick_y, button_byte_a, button_byte_b, button_byte_c (8 bits each)
    output logic [55:0] m_tdata
);
    import gerb_pkg::*;

    logic        ev_valid;
    event_t      ev;
    stage_ctrl_t ctrl;
    report_t     report_next;
    report_t     report_state;
    logic        out_free;

    // Hold the incoming event
    gerb_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .ctrl     (ctrl),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    // Apply the event to the report state
    gerb_report_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev_valid     (ev_valid),
        .ev           (ev),
        .out_free     (out_free),
        .ctrl         (ctrl),
        .report_next  (report_next),
        .report_state (report_state)
    );

    // Hold the finished report for the receiver
    gerb_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .report_next (report_next),
        .out_free    (out_free),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`include "gamepad_event_report_builder_assert.svh"

    // An empty input stage must always take a new item
    `GERB_ASSERT_ALWAYS(a_ready_when_empty, ev_valid || s_tready, "empty input stage not ready")

    // A button or axis event that moves on must show up as a result next cycle
    `GERB_ASSERT_NEXT(a_emit_loads_out, ctrl.advance && ctrl.emit, m_tvalid, "report lost")

    // An event of another kind must leave the report untouched
    `GERB_ASSERT_NEXT(a_other_holds, ev_valid && !ctrl.emit, $stable(report_state), "state moved")

    // The unused high bits of the last report byte stay clear
    `GERB_ASSERT_ALWAYS(a_byte_c_unused, report_state[6][7:1] == 7'd0, "unused report bits set")

endmodule
